@@ design/assert_macros.svh @@
// assertion macros used by the deframer rtl
// no dependencies; simulation builds get the checks, synthesis builds get nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked on clk_i, disabled while rst_ni is low
`define RSPDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rspdf assertion failed");

// explicit clock and active-low reset
`define RSPDF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rspdf assertion failed");

`else

`define RSPDF_ASSERT(lbl, prop)
`define RSPDF_ASSERT_CLK(lbl, clk, rstn, prop)

`endif

`endif

@@ design/rspdf_pkg.sv @@
// types, byte codes and helpers for the rsp packet deframer
// no dependencies
`default_nettype none

package rspdf_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned KindW       = 3;
  localparam int unsigned BodyLenW    = 12;
  localparam int unsigned DigitW      = 5;
  localparam int unsigned MaxPacketDef = 4096;

  localparam logic [ByteW-1:0] ByteCtrlC = 8'h03;
  localparam logic [ByteW-1:0] ByteStart = 8'h24;  // '$'
  localparam logic [ByteW-1:0] ByteHash  = 8'h23;  // '#'
  localparam logic [ByteW-1:0] BytePlus  = 8'h2b;  // '+'
  localparam logic [ByteW-1:0] ByteMinus = 8'h2d;  // '-'

  typedef enum logic [KindW-1:0] {
    KindBody = 3'd0,
    KindGood = 3'd1,
    KindBad  = 3'd2,
    KindIntr = 3'd3,
    KindOvfl = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PhHunt = 4'b0001,
    PhBody = 4'b0010,
    PhDig1 = 4'b0100,
    PhDig2 = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [ByteW-1:0]     body_byte;
    logic                 send_ack;
    logic [ByteW-1:0]     ack_byte;
    logic [BodyLenW-1:0]  body_length;
    logic                 sum_ok;
  } res_t;

  // value in bits 3..0, bit 4 set when the byte is not a hex digit
  function automatic logic [DigitW-1:0] hex_digit(input logic [ByteW-1:0] b);
    logic [DigitW-1:0] d;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = DigitW'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = DigitW'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = DigitW'(b - 8'h37);
    end else begin
      d = 5'h10;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/rspdf_if.sv @@
// valid/ready channel interfaces for received bytes, results and the mode register
// depends on rspdf_pkg
`default_nettype none

interface rspdf_rx_if;
  logic                       valid;
  logic                       ready;
  logic [rspdf_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rspdf_res_if;
  logic                          valid;
  logic                          ready;
  logic [rspdf_pkg::KindW-1:0]    kind;
  logic [rspdf_pkg::ByteW-1:0]    body_byte;
  logic                          send_ack;
  logic [rspdf_pkg::ByteW-1:0]    ack_byte;
  logic [rspdf_pkg::BodyLenW-1:0] body_length;
  logic                          sum_ok;

  modport source (output valid, output kind, output body_byte, output send_ack,
                  output ack_byte, output body_length, output sum_ok, input ready);
  modport sink   (input valid, input kind, input body_byte, input send_ack,
                  input ack_byte, input body_length, input sum_ok, output ready);
endinterface

interface rspdf_cfg_if;
  logic valid;
  logic ready;
  logic no_ack_mode;

  modport source (output valid, output no_ack_mode, input ready);
  modport sink   (input valid, input no_ack_mode, output ready);
endinterface

`default_nettype wire

@@ design/rspdf_core.sv @@
// packet phase machine: checksum, length and digit state, one byte per fire
// depends on rspdf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module rspdf_core #(
  parameter int unsigned MaxPacket = rspdf_pkg::MaxPacketDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic [rspdf_pkg::ByteW-1:0] byte_i,
  input  wire logic                        no_ack_i,
  output      logic                        has_res_o,
  output      rspdf_pkg::res_t             res_o
);
  import rspdf_pkg::*;

  localparam int unsigned LenW = $clog2(MaxPacket);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxPacket - 1);

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    sum_q, sum_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [DigitW-1:0]   hi_q, hi_d;
  logic [DigitW-1:0]   digit;
  logic                ok;

  assign digit = hex_digit(byte_i);
  assign ok    = !hi_q[DigitW-1] && !digit[DigitW-1] &&
                 ({hi_q[3:0], digit[3:0]} == sum_q);

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    len_d     = len_q;
    hi_d      = hi_q;
    has_res_o = 1'b0;
    res_o     = '0;
    res_o.kind = KindBody;
    case (phase_q)
      PhHunt: begin
        if (byte_i == ByteCtrlC) begin
          has_res_o  = 1'b1;
          res_o.kind = KindIntr;
        end else if (byte_i == ByteStart) begin
          phase_d = PhBody;
          sum_d   = '0;
          len_d   = '0;
          hi_d    = '0;
        end
      end
      PhBody: begin
        if (byte_i == ByteHash) begin
          phase_d = PhDig1;
        end else if (len_q >= LenMax) begin
          // body too long, byte dropped
          has_res_o         = 1'b1;
          res_o.kind        = KindOvfl;
          res_o.body_length = BodyLenW'(len_q);
          phase_d           = PhHunt;
        end else begin
          len_d             = len_q + 1'b1;
          sum_d             = sum_q + byte_i;
          has_res_o         = 1'b1;
          res_o.kind        = KindBody;
          res_o.body_byte   = byte_i;
          res_o.body_length = BodyLenW'(len_d);
        end
      end
      PhDig1: begin
        hi_d    = digit;
        phase_d = PhDig2;
      end
      PhDig2: begin
        has_res_o         = 1'b1;
        res_o.kind        = ok ? KindGood : KindBad;
        res_o.send_ack    = !no_ack_i;
        res_o.ack_byte    = no_ack_i ? '0 : (ok ? BytePlus : ByteMinus);
        res_o.body_length = BodyLenW'(len_q);
        res_o.sum_ok      = ok;
        phase_d           = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q   <= '0;
      len_q   <= '0;
      hi_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      hi_q    <= hi_d;
    end
  end

  `RSPDF_ASSERT(a_state_holds_idle, !fire_i |=> $stable(phase_q) && $stable(len_q))
  `RSPDF_ASSERT(a_ovfl_to_hunt,
    fire_i && has_res_o && res_o.kind == KindOvfl |=> phase_q == PhHunt)
  `RSPDF_ASSERT(a_start_clears,
    fire_i && phase_q == PhHunt && byte_i == ByteStart |=> len_q == '0 && sum_q == '0)
  `RSPDF_ASSERT(a_hash_keeps_len,
    fire_i && phase_q == PhBody && byte_i == ByteHash |=> phase_q == PhDig1 && $stable(len_q))

endmodule

`default_nettype wire

@@ design/rsp_packet_deframer_unit.sv @@
// top level of the rsp packet deframer: input register, phase machine, result register
// depends on rspdf_pkg, rspdf_if, rspdf_core
//
//   channel  dir  handshake    payload
//   rx_i     in   valid/ready  rx_byte
//   res_o    out  valid/ready  kind body_byte send_ack ack_byte body_length sum_ok
//   cfg_i    in   valid/ready  no_ack_mode (ready always high)
//
// one byte per cycle unless res_o stalls; accepted bytes pass input then result register
// the byte in the input register is processed as soon as the result register is free
// or the byte yields no item; bytes without a result never wait on res_o.ready
// reset puts the phase machine in hunting with sum and length cleared, no_ack_mode 0
`default_nettype none

module rsp_packet_deframer_unit #(
  parameter int unsigned MaxPacket = rspdf_pkg::MaxPacketDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rspdf_rx_if.sink     rx_i,
  rspdf_res_if.source  res_o,
  rspdf_cfg_if.sink    cfg_i
);
  import rspdf_pkg::*;

  logic             s1_vld_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             out_vld_q;
  res_t             out_q;
  logic             no_ack_q;
  logic             has_res;
  res_t             res;
  logic             out_free;
  logic             fire;

  assign out_free   = !out_vld_q || res_o.ready;
  assign fire       = s1_vld_q && (!has_res || out_free);
  assign rx_i.ready = !s1_vld_q || fire;
  assign cfg_i.ready = 1'b1;

  rspdf_core #(
    .MaxPacket (MaxPacket)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (s1_byte_q),
    .no_ack_i  (no_ack_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      no_ack_q  <= 1'b0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire && has_res) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        no_ack_q <= cfg_i.no_ack_mode;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (fire && has_res) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.body_byte   = out_q.body_byte;
  assign res_o.send_ack    = out_q.send_ack;
  assign res_o.ack_byte    = out_q.ack_byte;
  assign res_o.body_length = out_q.body_length;
  assign res_o.sum_ok      = out_q.sum_ok;

endmodule

`default_nettype wire
